// ===== src/lru_pkg.sv =====
// shared constants, types and state codes for the lru page replacement block
`default_nettype none

package lru_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;

  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int CFG_W   = 5;
  localparam int FAULT_W = 16;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [FAULT_W-1:0]   fault_t;
  typedef logic [CFG_W-1:0]     cfg_t;

  localparam idx_t   RANK_MAX  = idx_t'(FRAMES - 1);
  localparam fault_t FAULT_MAX = '1;
  localparam cfg_t   CFG_RESET = cfg_t'(16);

  // search record handed from frame to frame along the chain
  typedef struct packed {
    logic  valid;
    page_t page;
    logic  found;
    idx_t  hit_idx;
    idx_t  hit_rank;
    idx_t  best_rank;
    idx_t  best_idx;
    page_t best_page;
  } probe_t;

  // recency and content update broadcast to every frame
  typedef struct packed {
    logic  valid;
    logic  clear;
    logic  fill;
    logic  wr;
    idx_t  slot;
    idx_t  old_rank;
    page_t page;
  } upd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

endpackage

`default_nettype wire

// ===== src/lru_cell.sv =====
// one page frame: holds a page and its age, checks the passing search record
`default_nettype none

module lru_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire lru_pkg::idx_t   cell_idx_i,
  input  wire lru_pkg::cnt_t   active_i,
  input  wire lru_pkg::probe_t probe_i,
  output lru_pkg::probe_t      probe_o,
  input  wire lru_pkg::upd_t   upd_i
);

  lru_pkg::page_t  page_q, page_d;
  lru_pkg::idx_t   rank_q, rank_d;
  lru_pkg::probe_t probe_q, probe_d;
  logic            in_range;
  logic            is_slot;

  assign in_range = lru_pkg::cnt_t'(cell_idx_i) < active_i;
  assign is_slot  = cell_idx_i == upd_i.slot;

  always_comb begin
    probe_d = probe_i;
    if (probe_i.valid && in_range) begin
      if (!probe_i.found && page_q == probe_i.page) begin
        probe_d.found    = 1'b1;
        probe_d.hit_idx  = cell_idx_i;
        probe_d.hit_rank = rank_q;
      end
      // lowest frame always seeds the victim so an all-young set picks frame zero
      if (cell_idx_i == '0 || rank_q > probe_i.best_rank) begin
        probe_d.best_rank = rank_q;
        probe_d.best_idx  = cell_idx_i;
        probe_d.best_page = page_q;
      end
    end
  end

  always_comb begin
    rank_d = rank_q;
    page_d = page_q;
    if (upd_i.valid) begin
      if (upd_i.clear) begin
        rank_d = '0;
      end else begin
        if (upd_i.fill) begin
          if (in_range && rank_q != lru_pkg::RANK_MAX) begin
            rank_d = rank_q + 1'b1;
          end
        end else if (in_range && !is_slot && rank_q < upd_i.old_rank &&
                     rank_q != lru_pkg::RANK_MAX) begin
          rank_d = rank_q + 1'b1;
        end
        if (is_slot) begin
          rank_d = '0;
          if (upd_i.wr) begin
            page_d = upd_i.page;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= '0;
      probe_q <= '0;
    end else begin
      rank_q  <= rank_d;
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign probe_o = probe_q;

endmodule

`default_nettype wire

// ===== src/lru_page_replacement.sv =====
// lru page replacement: a search record walks the frame chain, registered at each frame
// the record passes each frame's register into rec_q; the result is registered on finish
// a new request is taken only in ST_IDLE, once the previous result has been registered
// a waiting result does not stall the next request's walk through the chain
// reset: async active low, clears ages, fill and fault counts, frames_in_use to 16
// frame pages are not cleared; only filled frames are ever compared
`default_nettype none

module lru_page_replacement (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire [4:0]  cfg_wdata_i,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire [15:0] page_number_i,
  input  wire        last_reference_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic       hit_o,
  output logic [3:0] frame_index_o,
  output logic       evicted_valid_o,
  output logic [15:0] evicted_page_o,
  output logic [15:0] fault_count_o
);

  lru_pkg::state_e state_q, state_d;
  lru_pkg::cfg_t   cfg_q;
  lru_pkg::cnt_t   filled_q, filled_d;
  lru_pkg::fault_t faults_q, faults_d;
  lru_pkg::page_t  page_q;
  logic            last_q;
  lru_pkg::probe_t rec_q;

  logic            out_valid_q;
  logic            hit_q;
  logic [3:0]      frame_idx_q;
  logic            evv_q;
  logic [15:0]     evp_q;
  lru_pkg::fault_t fault_cnt_q;

  lru_pkg::cnt_t   limit;
  lru_pkg::cnt_t   active;
  logic            accept;
  logic            finish;
  logic            has_room;
  logic            evict;
  lru_pkg::idx_t   slot;
  lru_pkg::fault_t faults_inc;
  lru_pkg::upd_t   upd;
  lru_pkg::probe_t chain [lru_pkg::FRAMES+1];

  always_comb begin
    if (cfg_q == '0) begin
      limit = lru_pkg::cnt_t'(1);
    end else if (int'(cfg_q) > lru_pkg::FRAMES) begin
      limit = lru_pkg::cnt_t'(lru_pkg::FRAMES);
    end else begin
      limit = lru_pkg::cnt_t'(cfg_q);
    end
  end

  assign active = (filled_q < limit) ? filled_q : limit;

  assign in_ready_o = state_q == lru_pkg::ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign finish     = (state_q == lru_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    chain[0]         = '0;
    chain[0].valid   = accept;
    chain[0].page    = lru_pkg::page_t'(page_number_i);
  end

  for (genvar g = 0; g < lru_pkg::FRAMES; g++) begin : g_frame
    lru_cell u_frame (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (lru_pkg::idx_t'(g)),
      .active_i   (active),
      .probe_i    (chain[g]),
      .probe_o    (chain[g+1]),
      .upd_i      (upd)
    );
  end

  // outcome of the finished search
  assign has_room   = filled_q < limit;
  assign evict      = !rec_q.found && !has_room;
  assign faults_inc = (faults_q == lru_pkg::FAULT_MAX) ? faults_q : faults_q + 1'b1;

  always_comb begin
    if (rec_q.found) begin
      slot = rec_q.hit_idx;
    end else if (has_room) begin
      slot = lru_pkg::idx_t'(filled_q);
    end else begin
      slot = rec_q.best_idx;
    end
  end

  always_comb begin
    upd          = '0;
    upd.valid    = finish;
    upd.clear    = last_q;
    upd.fill     = !rec_q.found && has_room;
    upd.wr       = !rec_q.found;
    upd.slot     = slot;
    upd.old_rank = rec_q.found ? rec_q.hit_rank : rec_q.best_rank;
    upd.page     = page_q;
  end

  always_comb begin
    filled_d = filled_q;
    faults_d = faults_q;
    if (finish) begin
      if (last_q) begin
        filled_d = '0;
        faults_d = '0;
      end else if (!rec_q.found) begin
        faults_d = faults_inc;
        if (has_room) begin
          filled_d = filled_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lru_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lru_pkg::ST_SCAN;
        end
      end
      lru_pkg::ST_SCAN: begin
        if (chain[lru_pkg::FRAMES].valid) begin
          state_d = lru_pkg::ST_DONE;
        end
      end
      lru_pkg::ST_DONE: begin
        if (finish) begin
          state_d = lru_pkg::ST_IDLE;
        end
      end
      default: state_d = lru_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lru_pkg::ST_IDLE;
      cfg_q       <= lru_pkg::CFG_RESET;
      filled_q    <= '0;
      faults_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      filled_q <= filled_d;
      faults_q <= faults_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= lru_pkg::page_t'(page_number_i);
      last_q <= last_reference_i;
    end
    if (state_q == lru_pkg::ST_SCAN && chain[lru_pkg::FRAMES].valid) begin
      rec_q <= chain[lru_pkg::FRAMES];
    end
    if (finish) begin
      hit_q       <= rec_q.found;
      frame_idx_q <= 4'(slot);
      evv_q       <= evict;
      evp_q       <= evict ? 16'(rec_q.best_page) : '0;
      fault_cnt_q <= rec_q.found ? faults_q : faults_inc;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = frame_idx_q;
  assign evicted_valid_o = evv_q;
  assign evicted_page_o  = evp_q;
  assign fault_count_o   = fault_cnt_q;

`ifndef SYNTHESIS
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_filled_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= lru_pkg::cnt_t'(lru_pkg::FRAMES))
    else $error("fill count beyond frame count");

  a_probe_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[lru_pkg::FRAMES].valid |-> state_q == lru_pkg::ST_SCAN)
    else $error("search record left the chain outside a scan");

  a_evict_on_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish && evict |-> !rec_q.found && filled_q >= limit)
    else $error("eviction without a full miss");

  a_no_fill_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish && upd.fill && !last_q |=> filled_q == $past(filled_q) + 1'b1)
    else $error("fill did not advance the fill count");
`endif

endmodule

`default_nettype wire
